FILE: rtl/core/iprcl_pkg.sv
// ----------------------------------------------------------------------------
// iprcl_pkg
// Shared types and constants of the address range country lookup block.
// ----------------------------------------------------------------------------
package iprcl_pkg;

    localparam int TableEntriesDefault = 256;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FOUND = 2'd1;
    localparam logic [1:0] STAT_MISS  = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    localparam logic [15:0] DEFAULT_SHORT = 16'h4E41;   // "NA"
    localparam logic [23:0] DEFAULT_MID   = 24'h4E2F41; // "N/A"

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] range_first;
        logic [31:0] range_last;
        logic [15:0] code_two_letter;
        logic [23:0] code_three_letter;
        logic [31:0] query_address;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_first;
        logic [31:0] found_last;
        logic [15:0] country_two_letter;
        logic [23:0] country_three_letter;
    } t_out;

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] last;
        logic [15:0] two;
        logic [23:0] three;
    } t_entry;

    localparam int EntryWidth = $bits(t_entry);

    typedef enum logic [2:0] {
        RES_NONE,
        RES_ACK,
        RES_FULL,
        RES_MISS,
        RES_HIT
    } t_res;

    typedef struct packed {
        logic load;       // capture input transaction, start search
        logic clear;      // empty the table
        logic srch_rd;    // read start at midpoint
        logic srch_upd;   // narrow search window
        logic prev_rd;    // read entry just below the search result
        logic shift_init; // start shifting from the table end
        logic shift_rd;   // read entry below the shift pointer
        logic shift_wr;   // write it one place up
        logic wr_over;    // overwrite entry with matching start
        logic wr_new;     // write new entry at its sorted place
        t_res res;        // result to hold for delivery
        logic out_load;   // move held result to the output register
    } t_cmd;

    typedef struct packed {
        logic is_lookup;
        logic skip;       // empty table or zero query
        logic srch_done;
        logic n_zero;
        logic start_eq;
        logic end_ok;
        logic full;
        logic shift_done;
        logic out_free;
    } t_stat;

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

FILE: rtl/core/iprcl_ram.sv
// ----------------------------------------------------------------------------
// iprcl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module iprcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/iprcl_dp.sv
// ----------------------------------------------------------------------------
// iprcl_dp
// Datapath: transaction registers, search window, shift pointer, entry count,
// table memory and output register.
// ----------------------------------------------------------------------------
module iprcl_dp #(
    parameter int TABLE_ENTRIES = iprcl_pkg::TableEntriesDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iprcl_pkg::t_in    i_in,
    input  iprcl_pkg::t_cmd   i_cmd,
    input  logic              i_out_stall,
    output iprcl_pkg::t_stat  o_stat,
    output logic              o_out_valid,
    output iprcl_pkg::t_out   o_out
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FullCount = CW'(TABLE_ENTRIES);
    localparam logic [CW-1:0] OneCount  = CW'(1);

    iprcl_pkg::t_in    r_in;
    logic [31:0]       r_key,   n_key;
    logic [CW-1:0]     r_lo,    n_lo;
    logic [CW-1:0]     r_hi,    n_hi;
    logic [AW-1:0]     r_mid,   n_mid;
    logic [CW-1:0]     r_j,     n_j;
    logic [CW-1:0]     r_count, n_count;
    iprcl_pkg::t_out   r_pend,  n_pend;
    iprcl_pkg::t_out   r_out;
    logic              r_out_vld, n_out_vld;

    logic [CW:0]                  mid_sum;
    logic [AW-1:0]                raddr, waddr;
    logic                         we;
    iprcl_pkg::t_entry            wdata, rdata;
    logic [CW-1:0]                lo_m1, j_m1;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign lo_m1   = r_lo - OneCount;
    assign j_m1    = r_j - OneCount;

    always_comb begin
        raddr = n_mid;
        if (i_cmd.prev_rd) begin
            raddr = lo_m1[AW-1:0];
        end else if (i_cmd.shift_rd) begin
            raddr = j_m1[AW-1:0];
        end
    end

    always_comb begin
        we    = i_cmd.shift_wr | i_cmd.wr_over | i_cmd.wr_new;
        waddr = r_lo[AW-1:0];
        wdata = {r_in.range_first, r_in.range_last,
                 r_in.code_two_letter, r_in.code_three_letter};
        if (i_cmd.shift_wr) begin
            waddr = r_j[AW-1:0];
            wdata = rdata;
        end else if (i_cmd.wr_over) begin
            waddr = lo_m1[AW-1:0];
        end
    end

    iprcl_ram #(
        .WIDTH(iprcl_pkg::EntryWidth),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        n_key     = r_key;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = mid_sum[AW:1];
        n_j       = r_j;
        n_count   = r_count;
        n_pend    = r_pend;
        n_out_vld = r_out_vld & i_out_stall;
        if (i_cmd.load) begin
            n_key = (i_in.mode == iprcl_pkg::MODE_INSERT) ? i_in.range_first
                                                           : iprcl_pkg::swap_bytes(
                                                                 i_in.query_address);
            n_lo  = '0;
            n_hi  = r_count;
        end
        if (i_cmd.srch_upd) begin
            if (rdata.first <= r_key) begin
                n_lo = CW'(r_mid) + OneCount;
            end else begin
                n_hi = CW'(r_mid);
            end
        end
        if (i_cmd.shift_init) begin
            n_j = r_count;
        end
        if (i_cmd.shift_wr) begin
            n_j = j_m1;
        end
        if (i_cmd.wr_new) begin
            n_count = r_count + OneCount;
        end
        if (i_cmd.clear) begin
            n_count = '0;
        end
        case (i_cmd.res)
            iprcl_pkg::RES_ACK:  n_pend = '{iprcl_pkg::STAT_DONE, 32'd0, 32'd0, 16'd0, 24'd0};
            iprcl_pkg::RES_FULL: n_pend = '{iprcl_pkg::STAT_FULL, 32'd0, 32'd0, 16'd0, 24'd0};
            iprcl_pkg::RES_MISS: n_pend = '{iprcl_pkg::STAT_MISS, 32'd0, 32'd0,
                                            iprcl_pkg::DEFAULT_SHORT,
                                            iprcl_pkg::DEFAULT_MID};
            iprcl_pkg::RES_HIT:  n_pend = '{iprcl_pkg::STAT_FOUND, rdata.first, rdata.last,
                                            rdata.two, rdata.three};
            default:             n_pend = r_pend;
        endcase
        if (i_cmd.out_load) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in;
        end
        if (i_cmd.out_load) begin
            r_out <= r_pend;
        end
        r_key  <= n_key;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_j    <= n_j;
        r_pend <= n_pend;
    end

    always_comb begin
        o_stat.is_lookup  = (r_in.mode == iprcl_pkg::MODE_LOOKUP);
        o_stat.skip       = (r_count == '0) || (r_in.query_address == 32'd0);
        o_stat.srch_done  = (r_lo == r_hi);
        o_stat.n_zero     = (r_lo == '0);
        o_stat.start_eq   = (rdata.first == r_key);
        o_stat.end_ok     = (rdata.last >= r_key);
        o_stat.full       = (r_count == FullCount);
        o_stat.shift_done = (r_j == r_lo);
        o_stat.out_free   = !r_out_vld || !i_out_stall;
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

FILE: rtl/core/iprcl_ctrl.sv
// ----------------------------------------------------------------------------
// iprcl_ctrl
// Controller: sequences search, shift, write and result delivery.
// ----------------------------------------------------------------------------
module iprcl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_in_mode,
    input  iprcl_pkg::t_stat  i_stat,
    output logic              o_in_stall,
    output iprcl_pkg::t_cmd   o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SRCH     = 7'b0000010,
        S_SRCH_CMP = 7'b0000100,
        S_PREV_CHK = 7'b0001000,
        S_SHIFT_RD = 7'b0010000,
        S_SHIFT_WR = 7'b0100000,
        S_RESP     = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res = iprcl_pkg::RES_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_mode == iprcl_pkg::MODE_INSERT ||
                        i_in_mode == iprcl_pkg::MODE_LOOKUP) begin
                        n_state = S_SRCH;
                    end else begin
                        o_cmd.clear = (i_in_mode == iprcl_pkg::MODE_CLEAR);
                        o_cmd.res   = iprcl_pkg::RES_ACK;
                        n_state     = S_RESP;
                    end
                end
            end
            S_SRCH: begin
                if (i_stat.is_lookup && i_stat.skip) begin
                    o_cmd.res = iprcl_pkg::RES_MISS;
                    n_state   = S_RESP;
                end else if (!i_stat.srch_done) begin
                    o_cmd.srch_rd = 1'b1;
                    n_state       = S_SRCH_CMP;
                end else if (!i_stat.n_zero) begin
                    o_cmd.prev_rd = 1'b1;
                    n_state       = S_PREV_CHK;
                end else if (i_stat.is_lookup) begin
                    o_cmd.res = iprcl_pkg::RES_MISS;
                    n_state   = S_RESP;
                end else if (i_stat.full) begin
                    o_cmd.res = iprcl_pkg::RES_FULL;
                    n_state   = S_RESP;
                end else begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SHIFT_RD;
                end
            end
            S_SRCH_CMP: begin
                o_cmd.srch_upd = 1'b1;
                n_state        = S_SRCH;
            end
            S_PREV_CHK: begin
                if (i_stat.is_lookup) begin
                    o_cmd.res = i_stat.end_ok ? iprcl_pkg::RES_HIT : iprcl_pkg::RES_MISS;
                    n_state   = S_RESP;
                end else if (i_stat.start_eq) begin
                    o_cmd.wr_over = 1'b1;
                    o_cmd.res     = iprcl_pkg::RES_ACK;
                    n_state       = S_RESP;
                end else if (i_stat.full) begin
                    o_cmd.res = iprcl_pkg::RES_FULL;
                    n_state   = S_RESP;
                end else begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_stat.shift_done) begin
                    o_cmd.wr_new = 1'b1;
                    o_cmd.res    = iprcl_pkg::RES_ACK;
                    n_state      = S_RESP;
                end else begin
                    o_cmd.shift_rd = 1'b1;
                    n_state        = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: rtl/core/ip_range_country_lookup.sv
// ----------------------------------------------------------------------------
// ip_range_country_lookup
// Sorted address range table with two- and three-letter country codes.
// ----------------------------------------------------------------------------
// One transaction at a time. A lookup byte-swaps the query, binary-searches
// the sorted table (each halving is one memory read, then one compare),
// reads the entry just below the search point and checks its end bound.
// An insert runs the same search, then moves every entry above the new
// start up by one place; each moved entry is read from the table memory,
// then written back one place higher. An overwrite of an existing start
// moves nothing. A clear resets the entry count. The result sits in an
// output register, so the next transaction is taken as soon as the result
// is handed over or parked there. The table memory needs no clearing after
// reset: only entries below the entry count are ever read.
// ----------------------------------------------------------------------------
module ip_range_country_lookup #(
    parameter int TABLE_ENTRIES = iprcl_pkg::TableEntriesDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  iprcl_pkg::t_in   i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output iprcl_pkg::t_out  o_out
);

    iprcl_pkg::t_cmd  cmd;
    iprcl_pkg::t_stat stat;

    // Controller: walks search, shift and write steps for each transaction.
    iprcl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_mode (i_in.mode),
        .i_stat    (stat),
        .o_in_stall(o_in_stall),
        .o_cmd     (cmd)
    );

    // Datapath: table memory, search window, entry count, output register.
    iprcl_dp #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .i_out_stall(i_out_stall),
        .o_stat     (stat),
        .o_out_valid(o_out_valid),
        .o_out      (o_out)
    );

    // A taken transaction always raises the input stall in the cycle after it is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while previous transaction still in work");

    // A found range always encloses a nonzero query, so its start is not above its end.
    a_found_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == iprcl_pkg::STAT_FOUND
        |-> o_out.found_first <= o_out.found_last)
        else $error("found range with start above end");

    // A miss reports the default codes.
    a_miss_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == iprcl_pkg::STAT_MISS
        |-> o_out.country_two_letter == iprcl_pkg::DEFAULT_SHORT &&
            o_out.found_first == 32'd0)
        else $error("miss without default codes");

endmodule
